[rtl/assert_macros.svh]
// Assertion helpers for the port-level checker, mlt_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, held off while reset is low.
`define MLT_ASSERT_ON(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Same, on the default clk / rst_n names.
`define MLT_ASSERT(lbl, prop, msg) `MLT_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

[rtl/mlt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_pkg
// Types and constants of the MAC learning table: operation and status codes,
// the command broadcast to the cells and the link handed along the chain.
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam int MAC_W    = 48;
  localparam int PORT_W   = 4;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 16;

  localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = 16'd300;

  typedef enum logic [KIND_W-1:0] {
    KIND_LEARN  = 3'd0,
    KIND_LOOKUP = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_BUSY = 2'd1,
    S_HOLD = 2'd2
  } state_t;

  // Operation held for the whole walk down the chain
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [MAC_W-1:0]   mac;
    logic [PORT_W-1:0]  port;
    logic               stat;
    logic [LIMIT_W-1:0] age_limit;
  } cmd_t;

  // Token passed from cell to cell
  typedef struct packed {
    logic              active;
    logic              found;
    logic              free_seen;
    logic [PORT_W-1:0] port;
  } link_t;

  // End-of-walk control back to every cell
  typedef struct packed {
    logic fin;
    logic commit;
  } ctl_t;

endpackage

[rtl/mlt_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_in_if
// Operation channel: valid/ready with kind, address, port and static flag.
// ----------------------------------------------------------------------------
interface mlt_in_if;
  logic                         valid;
  logic                         ready;
  logic [mlt_pkg::KIND_W-1:0]   kind;
  logic [mlt_pkg::MAC_W-1:0]    mac;
  logic [mlt_pkg::PORT_W-1:0]   port;
  logic                         entry_static;

  modport source (output valid, kind, mac, port, entry_static, input ready);
  modport sink   (input valid, kind, mac, port, entry_static, output ready);
endinterface

[rtl/mlt_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_out_if
// Result channel: valid/ready with hit flag, stored port and status.
// ----------------------------------------------------------------------------
interface mlt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [mlt_pkg::PORT_W-1:0]     out_port;
  logic [mlt_pkg::STATUS_W-1:0]   status;

  modport source (output valid, hit, out_port, status, input ready);
  modport sink   (input valid, hit, out_port, status, output ready);
endinterface

[rtl/mlt_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_cfg_if
// Configuration write channel for the age limit register.
// ----------------------------------------------------------------------------
interface mlt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mlt_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/mlt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_cell
// One table slot. Acts on the command in the cycle the token reaches it and
// hands the updated token to the next slot.
// ----------------------------------------------------------------------------
module mlt_cell #(
  parameter int AGE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mlt_pkg::cmd_t  cmd,
  input  mlt_pkg::ctl_t  ctl,
  input  mlt_pkg::link_t link_in,
  output mlt_pkg::link_t link_out
);

  localparam int CMP_W = (AGE_BITS > mlt_pkg::LIMIT_W) ? AGE_BITS : mlt_pkg::LIMIT_W;

  logic                        valid_r, valid_nxt;
  logic                        claim_r, claim_nxt;
  logic [mlt_pkg::MAC_W-1:0]   mac_r, mac_nxt;
  logic [mlt_pkg::PORT_W-1:0]  port_r, port_nxt;
  logic                        stat_r, stat_nxt;
  logic [AGE_BITS-1:0]         age_r, age_nxt;
  mlt_pkg::link_t              link_r, link_nxt;

  logic                        match;
  logic                        take;
  logic                        is_insert;
  logic                        claim;
  logic [AGE_BITS-1:0]         age_inc;

  assign match     = valid_r && (mac_r == cmd.mac);
  assign take      = link_in.active && match && !link_in.found;
  assign is_insert = (cmd.kind == mlt_pkg::KIND_LEARN) || (cmd.kind == mlt_pkg::KIND_ADD);
  // lowest free slot takes the entry provisionally; valid follows on commit
  assign claim     = link_in.active && is_insert && !valid_r &&
                     !link_in.free_seen && !link_in.found;
  assign age_inc   = (age_r == {AGE_BITS{1'b1}}) ? age_r : age_r + AGE_BITS'(1);

  always_comb begin
    valid_nxt = valid_r;
    claim_nxt = claim_r;
    mac_nxt   = mac_r;
    port_nxt  = port_r;
    stat_nxt  = stat_r;
    age_nxt   = age_r;
    link_nxt  = '0;
    if (link_in.active) begin
      link_nxt = link_in;
      if (take) begin
        link_nxt.found = 1'b1;
        link_nxt.port  = port_r;
        unique case (cmd.kind)
          mlt_pkg::KIND_LEARN: begin
            if (!stat_r) port_nxt = cmd.port;
          end
          mlt_pkg::KIND_LOOKUP: age_nxt   = '0;
          mlt_pkg::KIND_DELETE: valid_nxt = 1'b0;
          default: ;
        endcase
      end
      if (claim) begin
        link_nxt.free_seen = 1'b1;
        claim_nxt = 1'b1;
        mac_nxt   = cmd.mac;
        port_nxt  = cmd.port;
        stat_nxt  = (cmd.kind == mlt_pkg::KIND_ADD) && cmd.stat;
        age_nxt   = '0;
      end
      if ((cmd.kind == mlt_pkg::KIND_TICK) && valid_r) begin
        age_nxt = age_inc;
        if (CMP_W'(age_inc) >= CMP_W'(cmd.age_limit)) valid_nxt = 1'b0;
      end
    end
    if (ctl.fin) begin
      claim_nxt = 1'b0;
      if (ctl.commit && claim_r) valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      claim_r <= 1'b0;
      link_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      claim_r <= claim_nxt;
      link_r  <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r  <= mac_nxt;
    port_r <= port_nxt;
    stat_r <= stat_nxt;
    age_r  <= age_nxt;
  end

  assign link_out = link_r;

endmodule

[rtl/mlt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_ctrl
// Channel control: takes one operation, launches the token into the chain,
// settles the result at the chain end and holds it for the output.
// ----------------------------------------------------------------------------
module mlt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  mlt_in_if.sink          in_if,
  mlt_out_if.source       out_if,
  mlt_cfg_if.sink         cfg_if,
  output mlt_pkg::cmd_t   cmd,
  output mlt_pkg::ctl_t   ctl,
  output mlt_pkg::link_t  link_head,
  input  mlt_pkg::link_t  link_tail
);

  mlt_pkg::state_t                 state_r, state_nxt;
  logic                            start_r, start_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [mlt_pkg::LIMIT_W-1:0]     age_limit_r;
  mlt_pkg::cmd_t                   cmd_r;

  logic                            hold_hit_r;
  logic [mlt_pkg::PORT_W-1:0]      hold_port_r;
  logic [mlt_pkg::STATUS_W-1:0]    hold_status_r;
  logic                            out_hit_r;
  logic [mlt_pkg::PORT_W-1:0]      out_port_r;
  logic [mlt_pkg::STATUS_W-1:0]    out_status_r;

  logic                            in_acc;
  logic                            cfg_acc;
  logic                            fin;
  logic                            load_out;
  logic                            is_insert;
  logic                            res_hit;
  logic [mlt_pkg::PORT_W-1:0]      res_port;
  logic [mlt_pkg::STATUS_W-1:0]    res_status;
  logic [mlt_pkg::STATUS_W-1:0]    ins_status;

  assign in_if.ready  = (state_r == mlt_pkg::S_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid && cfg_if.ready;
  assign fin          = link_tail.active;
  assign is_insert    = (cmd_r.kind == mlt_pkg::KIND_LEARN) || (cmd_r.kind == mlt_pkg::KIND_ADD);

  always_comb begin
    state_nxt = state_r;
    start_nxt = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      mlt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = mlt_pkg::S_BUSY;
          start_nxt = 1'b1;
        end
      end
      mlt_pkg::S_BUSY: begin
        if (fin) state_nxt = mlt_pkg::S_HOLD;
      end
      mlt_pkg::S_HOLD: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = mlt_pkg::S_IDLE;
        end
      end
      default: state_nxt = mlt_pkg::S_IDLE;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_if.ready);
  end

  // result from the token as it leaves the last slot
  always_comb begin
    res_hit    = 1'b0;
    res_port   = '0;
    res_status = mlt_pkg::ST_DONE;
    ins_status = link_tail.free_seen ? mlt_pkg::ST_DONE : mlt_pkg::ST_FULL;
    unique case (mlt_pkg::kind_t'(cmd_r.kind)) inside
      mlt_pkg::KIND_LEARN, mlt_pkg::KIND_ADD: begin
        res_hit    = link_tail.found;
        res_status = link_tail.found ? mlt_pkg::ST_PRESENT : ins_status;
      end
      mlt_pkg::KIND_LOOKUP: begin
        res_hit    = link_tail.found;
        res_port   = link_tail.found ? link_tail.port : '0;
        res_status = link_tail.found ? mlt_pkg::ST_DONE : mlt_pkg::ST_MISSING;
      end
      mlt_pkg::KIND_DELETE: begin
        res_hit    = link_tail.found;
        res_status = link_tail.found ? mlt_pkg::ST_DONE : mlt_pkg::ST_MISSING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlt_pkg::S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      age_limit_r <= mlt_pkg::AGE_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc) age_limit_r <= cfg_if.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r.kind      <= in_if.kind;
      cmd_r.mac       <= in_if.mac;
      cmd_r.port      <= in_if.port;
      cmd_r.stat      <= in_if.entry_static;
      // a limit written on the same edge applies to this transaction
      cmd_r.age_limit <= cfg_acc ? cfg_if.data : age_limit_r;
    end
    if (fin) begin
      hold_hit_r    <= res_hit;
      hold_port_r   <= res_port;
      hold_status_r <= res_status;
    end
    if (load_out) begin
      out_hit_r    <= hold_hit_r;
      out_port_r   <= hold_port_r;
      out_status_r <= hold_status_r;
    end
  end

  assign cmd = cmd_r;

  assign ctl.fin    = fin;
  assign ctl.commit = fin && is_insert && !link_tail.found && link_tail.free_seen;

  assign link_head.active    = start_r;
  assign link_head.found     = 1'b0;
  assign link_head.free_seen = 1'b0;
  assign link_head.port      = '0;

  assign out_if.valid    = out_valid_r;
  assign out_if.hit      = out_hit_r;
  assign out_if.out_port = out_port_r;
  assign out_if.status   = out_status_r;

endmodule

[rtl/mac_learning_table_with_aging_core.sv]
`timescale 1ns / 1ps
// One operation at a time: the next is taken only once the last result has been
// loaded into the output register. The token walks the slot chain one slot a
// cycle; on leaving the last slot it commits the entry and the result is held.
// A result waiting at the output does not stop the next operation being taken.
// Reset (rst_n low, synchronous) empties the table and sets age_limit to 300.
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging_core
// MAC forwarding table with learning, lookup, add, delete and aging, built as
// a chain of slot cells that an operation token walks through.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int AGE_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mlt_in_if.sink     in_if,
  mlt_out_if.source  out_if,
  mlt_cfg_if.sink    cfg_if
);

  mlt_pkg::cmd_t  cmd;
  mlt_pkg::ctl_t  ctl;
  mlt_pkg::link_t link [0:TABLE_ENTRIES];

  mlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_if    (cfg_if),
    .cmd       (cmd),
    .ctl       (ctl),
    .link_head (link[0]),
    .link_tail (link[TABLE_ENTRIES])
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    mlt_cell #(
      .AGE_BITS (AGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .ctl      (ctl),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

endmodule

[rtl/mlt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_checker
// Port-level checks on the learning table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic [mlt_pkg::PORT_W-1:0]    out_port,
  input logic [mlt_pkg::STATUS_W-1:0]  out_status
);

  // a stalled result transaction stays offered
  `MLT_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // one operation in flight: ready drops right after a transaction
  `MLT_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second operation taken early")

  // a non-zero port only comes back from a lookup hit
  `MLT_ASSERT(a_port_on_hit, out_valid && (out_port != '0) |-> out_hit && (out_status == mlt_pkg::ST_DONE), "port on a non-hit result")

  // already present means hit, table full means miss
  `MLT_ASSERT(a_status_hit, out_valid && (out_status == mlt_pkg::ST_PRESENT || out_status == mlt_pkg::ST_FULL) |-> (out_hit == (out_status == mlt_pkg::ST_PRESENT)), "hit flag disagrees with status")

endmodule

bind mac_learning_table_with_aging_core mlt_checker u_mlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_hit    (out_if.hit),
  .out_port   (out_if.out_port),
  .out_status (out_if.status)
);

[bench/mlt_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_table_checker
// Watches the operation, result and age limit channels of the MAC learning
// table. It keeps its own copy of the forwarding table, works out the reply
// to every accepted operation and compares each accepted result with the
// oldest reply still owed.
// ----------------------------------------------------------------------------
module mlt_table_checker #(
  parameter int TABLE_ENTRIES = 64,
  parameter int AGE_BITS      = 16
) (
  input  logic clk,
  input  logic rst_n,
  mlt_in_if    in_ch,
  mlt_out_if   out_ch,
  mlt_cfg_if   cfg_ch,
  output int   errors,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    logic                       hit;
    logic [mlt_pkg::PORT_W-1:0] port;
    mlt_pkg::status_t           status;
  } table_reply_t;

  logic                         slot_valid  [TABLE_ENTRIES];
  logic [mlt_pkg::MAC_W-1:0]    slot_mac    [TABLE_ENTRIES];
  logic [mlt_pkg::PORT_W-1:0]   slot_port   [TABLE_ENTRIES];
  logic                         slot_static [TABLE_ENTRIES];
  logic [AGE_BITS-1:0]          slot_age    [TABLE_ENTRIES];
  logic [mlt_pkg::LIMIT_W-1:0]  age_limit_q;

  table_reply_t replies_due[$];
  int           err_count = 0;
  int           due_count = 0;
  int           reply_count = 0;

  assign errors  = err_count;
  assign pending = due_count;
  assign checked = reply_count;

  // lowest-numbered matching slot, -1 when absent
  function automatic int match_slot(input logic [mlt_pkg::MAC_W-1:0] mac);
    for (int k = 0; k < TABLE_ENTRIES; k++)
      if (slot_valid[k] && slot_mac[k] == mac) return k;
    return -1;
  endfunction

  function automatic mlt_pkg::status_t claim_free_slot(
      input logic [mlt_pkg::MAC_W-1:0]  mac,
      input logic [mlt_pkg::PORT_W-1:0] port,
      input logic                       stat);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (!slot_valid[k]) begin
        slot_valid[k]  = 1'b1;
        slot_mac[k]    = mac;
        slot_port[k]   = port;
        slot_static[k] = stat;
        slot_age[k]    = '0;
        return mlt_pkg::ST_DONE;
      end
    end
    return mlt_pkg::ST_FULL;
  endfunction

  function automatic table_reply_t run_table_op(
      input logic [mlt_pkg::KIND_W-1:0] kind,
      input logic [mlt_pkg::MAC_W-1:0]  mac,
      input logic [mlt_pkg::PORT_W-1:0] port,
      input logic                       stat);
    table_reply_t r;
    int           k;
    r.hit    = 1'b0;
    r.port   = '0;
    r.status = mlt_pkg::ST_DONE;
    k = match_slot(mac);
    case (kind)
      mlt_pkg::KIND_LEARN: begin
        if (k >= 0) begin
          r.hit    = 1'b1;
          r.status = mlt_pkg::ST_PRESENT;
          // static entries keep their port; age is never touched here
          if (!slot_static[k]) slot_port[k] = port;
        end else begin
          r.status = claim_free_slot(mac, port, 1'b0);
        end
      end
      mlt_pkg::KIND_LOOKUP: begin
        if (k >= 0) begin
          r.hit       = 1'b1;
          r.port      = slot_port[k];
          slot_age[k] = '0;
        end else begin
          r.status = mlt_pkg::ST_MISSING;
        end
      end
      mlt_pkg::KIND_ADD: begin
        if (k >= 0) begin
          r.hit    = 1'b1;
          r.status = mlt_pkg::ST_PRESENT;
        end else begin
          r.status = claim_free_slot(mac, port, stat);
        end
      end
      mlt_pkg::KIND_DELETE: begin
        if (k >= 0) begin
          r.hit         = 1'b1;
          slot_valid[k] = 1'b0;
        end else begin
          r.status = mlt_pkg::ST_MISSING;
        end
      end
      mlt_pkg::KIND_TICK: begin
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
          if (slot_valid[s]) begin
            if (slot_age[s] != '1) slot_age[s] = slot_age[s] + 1'b1;
            if (slot_age[s] >= age_limit_q) slot_valid[s] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      for (int s = 0; s < TABLE_ENTRIES; s++) slot_valid[s] = 1'b0;
      age_limit_q = mlt_pkg::AGE_LIMIT_RESET;
      replies_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) age_limit_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        replies_due.push_back(run_table_op(in_ch.kind, in_ch.mac, in_ch.port,
                                           in_ch.entry_static));
      if (out_ch.valid && out_ch.ready) begin
        reply_count++;
        if (replies_due.size() == 0) begin
          $error("result transaction with no operation outstanding");
          err_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_ch.hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, out_ch.hit);
            err_count++;
          end
          if (out_ch.out_port !== want.port) begin
            $error("out_port: expected %0d, got %0d", want.port, out_ch.out_port);
            err_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            err_count++;
          end
        end
      end
    end
    due_count = replies_due.size();
  end

endmodule

[bench/mac_learning_table_with_aging_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging_core_test
// Drives the MAC learning table with directed corner operations and then
// random operation mixes over several age limits, including a table fill
// past capacity, with random idling on both channels. Checking is done by
// mlt_table_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging_core_test;

  localparam int TABLE_ENTRIES  = 64;
  localparam int AGE_BITS       = 16;
  localparam int POOL_SIZE      = 96;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic calm;
  int   errors;
  int   pending;
  int   checked;
  int   ops_sent = 0;
  int   limits_used = 0;
  int   quiet_cycles = 0;

  logic [mlt_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];

  mlt_in_if  in_ch();
  mlt_out_if out_ch();
  mlt_cfg_if cfg_ch();

  mac_learning_table_with_aging_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AGE_BITS     (AGE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  mlt_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AGE_BITS     (AGE_BITS)
  ) checker_i (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .errors (errors),
    .pending(pending),
    .checked(checked)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side back-pressure
  always begin
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_op(input logic [mlt_pkg::KIND_W-1:0] kind,
                         input logic [mlt_pkg::MAC_W-1:0]  mac,
                         input logic [mlt_pkg::PORT_W-1:0] port,
                         input logic                       stat);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.mac          <= mac;
    in_ch.port         <= port;
    in_ch.entry_static <= stat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    ops_sent++;
  endtask

  // only written with nothing in flight
  task automatic write_age_limit(input logic [mlt_pkg::LIMIT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    limits_used++;
  endtask

  task automatic send_random_op(input int span);
    int                         pick;
    logic [mlt_pkg::KIND_W-1:0] kind;
    logic [mlt_pkg::MAC_W-1:0]  mac;
    pick = $urandom_range(0, 99);
    if (pick < 25) kind = mlt_pkg::KIND_LEARN;
    else if (pick < 55) kind = mlt_pkg::KIND_LOOKUP;
    else if (pick < 70) kind = mlt_pkg::KIND_ADD;
    else if (pick < 82) kind = mlt_pkg::KIND_DELETE;
    else if (pick < 95) kind = mlt_pkg::KIND_TICK;
    else kind = mlt_pkg::KIND_W'($urandom_range(int'(mlt_pkg::KIND_TICK) + 1,
                                                (1 << mlt_pkg::KIND_W) - 1));
    if ($urandom_range(0, 9) == 0) mac = {16'($urandom()), $urandom()};
    else mac = mac_pool[$urandom_range(0, span - 1)];
    send_op(kind, mac, mlt_pkg::PORT_W'($urandom()), 1'($urandom()));
  endtask

  initial begin
    logic [mlt_pkg::LIMIT_W-1:0] phase_limit [5];
    rst_n              = 1'b0;
    calm               = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = mlt_pkg::KIND_LEARN;
    in_ch.mac          = '0;
    in_ch.port         = '0;
    in_ch.entry_static = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = {16'($urandom()), $urandom()};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset age limit
    send_op(mlt_pkg::KIND_LEARN, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_LEARN, '1, '1, 1'b1);
    send_op(mlt_pkg::KIND_LEARN, '0, 4'd9, 1'b0);          // known address moves port
    send_op(mlt_pkg::KIND_LOOKUP, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_LOOKUP, mac_pool[95], '0, 1'b0); // miss
    send_op(mlt_pkg::KIND_ADD, mac_pool[90], 4'd5, 1'b1);
    send_op(mlt_pkg::KIND_ADD, mac_pool[90], 4'd3, 1'b0);  // duplicate add
    send_op(mlt_pkg::KIND_LEARN, mac_pool[90], 4'd2, 1'b0); // static keeps its port
    send_op(mlt_pkg::KIND_LOOKUP, mac_pool[90], '0, 1'b0);
    send_op(mlt_pkg::KIND_ADD, mac_pool[91], 4'd7, 1'b0);
    send_op(mlt_pkg::KIND_DELETE, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_DELETE, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_TICK, '1, '1, 1'b1);
    for (int k = int'(mlt_pkg::KIND_TICK) + 1; k < (1 << mlt_pkg::KIND_W); k++)
      send_op(mlt_pkg::KIND_W'(k), mac_pool[90], '1, 1'b1);

    // lookup restarts the age, then two ticks remove the entry
    write_age_limit(16'd2);
    send_op(mlt_pkg::KIND_LEARN, mac_pool[92], 4'd12, 1'b0);
    send_op(mlt_pkg::KIND_TICK, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_LOOKUP, mac_pool[92], '0, 1'b0);
    send_op(mlt_pkg::KIND_TICK, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_TICK, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_LOOKUP, mac_pool[92], '0, 1'b0);

    // zero limit clears even static entries on a tick
    write_age_limit('0);
    send_op(mlt_pkg::KIND_ADD, mac_pool[93], 4'd1, 1'b1);
    send_op(mlt_pkg::KIND_TICK, '0, '0, 1'b0);
    send_op(mlt_pkg::KIND_LOOKUP, mac_pool[93], '0, 1'b0);

    // fill past capacity, then mixed traffic on a full table
    write_age_limit('1);
    for (int i = 0; i < TABLE_ENTRIES + 8; i++)
      send_op($urandom_range(0, 1) ? mlt_pkg::KIND_ADD : mlt_pkg::KIND_LEARN, mac_pool[i],
              mlt_pkg::PORT_W'($urandom()), 1'($urandom()));
    repeat (40) send_random_op(POOL_SIZE);

    phase_limit[0] = 16'd1;
    phase_limit[1] = 16'd4;
    phase_limit[2] = mlt_pkg::LIMIT_W'($urandom_range(2, 20));
    phase_limit[3] = mlt_pkg::AGE_LIMIT_RESET;
    phase_limit[4] = mlt_pkg::LIMIT_W'($urandom_range(1, 65535));
    for (int p = 0; p < 5; p++) begin
      write_age_limit(phase_limit[p]);
      if (p == 4) calm = 1'b1;
      repeat (65) send_random_op(POOL_SIZE);
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TABLE_ENTRIES + 8) @(negedge clk);

    $display("covered %0d operations under %0d age limit settings, %0d results compared",
             ops_sent, limits_used + 1, checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
